FILE: hdl/bdl_pkg.sv
`timescale 1ns / 1ps

package bdl_pkg;

	// Configuration word width and register index width
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	// Default counter width
	localparam int COUNT_WIDTH_DEF = 16;

	// Register reset values
	localparam logic [CFG_W-1:0] DEBOUNCE_TICKS_RST   = 16'd15;
	localparam logic [CFG_W-1:0] SHORT_PRESS_MAX_RST  = 16'd1000;
	localparam logic [CFG_W-1:0] LONG_PRESS_MIN_RST   = 16'd3000;
	localparam logic [CFG_W-1:0] SLOW_HALF_PERIOD_RST = 16'd500;
	localparam logic [CFG_W-1:0] FAST_HALF_PERIOD_RST = 16'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE_TICKS   = 3'd0,
		REG_SHORT_PRESS_MAX  = 3'd1,
		REG_LONG_PRESS_MIN   = 3'd2,
		REG_SLOW_HALF_PERIOD = 3'd3,
		REG_FAST_HALF_PERIOD = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_SLOW = 2'd1,
		MODE_FAST = 2'd2
	} blink_mode_t;

	// Transitions of the debounced level within one tick
	typedef struct packed {
		logic fall;   // became pressed
		logic rise;   // became released
	} btn_edge_t;

endpackage

FILE: hdl/bdl_debounce.sv
`timescale 1ns / 1ps

module bdl_debounce #(
	parameter int COUNT_WIDTH = bdl_pkg::COUNT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       raw,
	input  logic [bdl_pkg::CFG_W-1:0]  debounce_ticks,
	output logic                       stable_nxt,
	output bdl_pkg::btn_edge_t         edges
);
	import bdl_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	logic                   filtered_q;
	logic                   pending_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   stable_q;

	logic                   changed;
	logic                   pend_nxt;
	logic                   take;
	logic [COUNT_WIDTH-1:0] count_nxt;

	always_comb begin
		changed = raw != filtered_q;
		if (changed) begin
			count_nxt = '0;
		end else if (&count_q) begin
			count_nxt = count_q;
		end else begin
			count_nxt = count_q + COUNT_WIDTH'(1);
		end
		take       = (changed || pending_q) &&
		             (CMP_W'(count_nxt) >= CMP_W'(debounce_ticks));
		pend_nxt   = (changed || pending_q) && !take;
		stable_nxt = take ? raw : stable_q;
		edges.fall = stable_q && !stable_nxt;
		edges.rise = !stable_q && stable_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filtered_q <= 1'b1;
			pending_q  <= 1'b0;
			count_q    <= '0;
			stable_q   <= 1'b1;
		end else if (step) begin
			filtered_q <= raw;
			pending_q  <= pend_nxt;
			count_q    <= count_nxt;
			stable_q   <= stable_nxt;
		end
	end

endmodule

FILE: hdl/bdl_press.sv
`timescale 1ns / 1ps

module bdl_press #(
	parameter int COUNT_WIDTH = bdl_pkg::COUNT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  bdl_pkg::btn_edge_t         edges,
	input  logic [bdl_pkg::CFG_W-1:0]  short_press_max,
	input  logic [bdl_pkg::CFG_W-1:0]  long_press_min,
	output bdl_pkg::blink_mode_t       mode_nxt,
	output logic                       short_hit,
	output logic                       long_hit
);
	import bdl_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	logic [COUNT_WIDTH-1:0] hold_q;
	logic                   long_pend_q;
	blink_mode_t            mode_q;

	logic [COUNT_WIDTH-1:0] hold_inc;
	logic [COUNT_WIDTH-1:0] hold_nxt;
	logic                   pend_mid;
	logic                   long_pend_nxt;

	always_comb begin
		hold_inc  = (&hold_q) ? hold_q : hold_q + COUNT_WIDTH'(1);
		hold_nxt  = hold_inc;
		pend_mid  = long_pend_q;
		mode_nxt  = mode_q;
		short_hit = 1'b0;
		if (edges.fall) begin
			// advance off -> slow -> fast -> off
			case (mode_q)
				MODE_SLOW: mode_nxt = MODE_FAST;
				MODE_FAST: mode_nxt = MODE_OFF;
				default:   mode_nxt = MODE_SLOW;
			endcase
			pend_mid = 1'b1;
			hold_nxt = '0;
		end else if (edges.rise) begin
			short_hit = CMP_W'(hold_inc) <= CMP_W'(short_press_max);
			pend_mid  = 1'b0;
		end
		long_hit      = pend_mid && (CMP_W'(hold_nxt) >= CMP_W'(long_press_min));
		long_pend_nxt = pend_mid && !long_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q      <= '0;
			long_pend_q <= 1'b0;
			mode_q      <= MODE_OFF;
		end else if (step) begin
			hold_q      <= hold_nxt;
			long_pend_q <= long_pend_nxt;
			mode_q      <= mode_nxt;
		end
	end

endmodule

FILE: hdl/bdl_blink.sv
`timescale 1ns / 1ps

module bdl_blink #(
	parameter int COUNT_WIDTH = bdl_pkg::COUNT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  bdl_pkg::blink_mode_t       mode,
	input  logic [bdl_pkg::CFG_W-1:0]  slow_half_period,
	input  logic [bdl_pkg::CFG_W-1:0]  fast_half_period,
	output logic                       pin_nxt
);
	import bdl_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	logic                   pin_q;
	logic [COUNT_WIDTH-1:0] slow_q;
	logic [COUNT_WIDTH-1:0] fast_q;
	logic [COUNT_WIDTH-1:0] slow_nxt;
	logic [COUNT_WIDTH-1:0] fast_nxt;

	always_comb begin
		// both counters run in every mode
		slow_nxt = (&slow_q) ? slow_q : slow_q + COUNT_WIDTH'(1);
		fast_nxt = (&fast_q) ? fast_q : fast_q + COUNT_WIDTH'(1);
		pin_nxt  = pin_q;
		case (mode)
			MODE_SLOW: begin
				if (CMP_W'(slow_nxt) >= CMP_W'(slow_half_period)) begin
					pin_nxt  = !pin_q;
					slow_nxt = '0;
				end
			end
			MODE_FAST: begin
				if (CMP_W'(fast_nxt) >= CMP_W'(fast_half_period)) begin
					pin_nxt  = !pin_q;
					fast_nxt = '0;
				end
			end
			default: pin_nxt = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q  <= 1'b1;
			slow_q <= '0;
			fast_q <= '0;
		end else if (step) begin
			pin_q  <= pin_nxt;
			slow_q <= slow_nxt;
			fast_q <= fast_nxt;
		end
	end

endmodule

FILE: hdl/button_debounce_led_mode_blinker_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake                  Word contents
// --------  -------------------------  ------------------------------------------------
// input     in_valid / in_ready        raw_level (one millisecond tick sample)
// output    out_valid / out_ready      led_pin, blink_mode, stable_level, press_event,
//                                      release_event, short_press, long_press
// config    cfg_wr_en (no handshake)   cfg_index, cfg_data
//
// One word per cycle sustained while out_ready is high; a word passes the input
// register, then the result register loaded by the update logic, before out_valid rises.
// Reset clears the handshake valids, the tick state and the configuration registers
// to their defaults.
// A stalled output holds the result register; the input register keeps taking a
// new word in the same cycle the result is drained, so throughput only drops while
// out_ready stays low.

module button_debounce_led_mode_blinker_unit #(
	parameter int COUNT_WIDTH = bdl_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wr_en,
	input  logic [bdl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bdl_pkg::CFG_W-1:0]     cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          raw_level,
	// output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          led_pin,
	output logic [1:0]                    blink_mode,
	output logic                          stable_level,
	output logic                          press_event,
	output logic                          release_event,
	output logic                          short_press,
	output logic                          long_press
);
	import bdl_pkg::*;

	// configuration registers
	logic [CFG_W-1:0] debounce_ticks_q;
	logic [CFG_W-1:0] short_press_max_q;
	logic [CFG_W-1:0] long_press_min_q;
	logic [CFG_W-1:0] slow_half_period_q;
	logic [CFG_W-1:0] fast_half_period_q;

	// input stage
	logic valid_s1;
	logic raw_s1;

	// result register
	logic        out_valid_q;
	logic        pin_q;
	logic [1:0]  mode_q;
	logic        stable_q;
	logic        press_q;
	logic        release_q;
	logic        short_q;
	logic        long_q;

	// tick update strobe: the stage-1 word moves into the result register
	logic        step;
	logic        stable_nxt;
	btn_edge_t   edges;
	blink_mode_t mode_nxt;
	logic        short_hit;
	logic        long_hit;
	logic        pin_nxt;

	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q   <= DEBOUNCE_TICKS_RST;
			short_press_max_q  <= SHORT_PRESS_MAX_RST;
			long_press_min_q   <= LONG_PRESS_MIN_RST;
			slow_half_period_q <= SLOW_HALF_PERIOD_RST;
			fast_half_period_q <= FAST_HALF_PERIOD_RST;
		end else if (cfg_wr_en) begin
			// drop writes to unknown indexes
			case (cfg_index)
				REG_DEBOUNCE_TICKS:   debounce_ticks_q   <= cfg_data;
				REG_SHORT_PRESS_MAX:  short_press_max_q  <= cfg_data;
				REG_LONG_PRESS_MIN:   long_press_min_q   <= cfg_data;
				REG_SLOW_HALF_PERIOD: slow_half_period_q <= cfg_data;
				REG_FAST_HALF_PERIOD: fast_half_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register: hold the word until the update logic consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			raw_s1 <= raw_level;
		end
	end

	bdl_debounce #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_debounce (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.raw           (raw_s1),
		.debounce_ticks(debounce_ticks_q),
		.stable_nxt    (stable_nxt),
		.edges         (edges)
	);

	bdl_press #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_press (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.edges          (edges),
		.short_press_max(short_press_max_q),
		.long_press_min (long_press_min_q),
		.mode_nxt       (mode_nxt),
		.short_hit      (short_hit),
		.long_hit       (long_hit)
	);

	// LED logic sees the mode already updated by this tick's press
	bdl_blink #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_blink (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.mode            (mode_nxt),
		.slow_half_period(slow_half_period_q),
		.fast_half_period(fast_half_period_q),
		.pin_nxt         (pin_nxt)
	);

	// result register: load on step, clear valid once the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			pin_q     <= pin_nxt;
			mode_q    <= mode_nxt;
			stable_q  <= stable_nxt;
			press_q   <= edges.fall;
			release_q <= edges.rise;
			short_q   <= short_hit;
			long_q    <= long_hit;
		end
	end

	assign out_valid     = out_valid_q;
	assign led_pin       = pin_q;
	assign blink_mode    = mode_q;
	assign stable_level  = stable_q;
	assign press_event   = press_q;
	assign release_event = release_q;
	assign short_press   = short_q;
	assign long_press    = long_q;

	// a tick cannot both press and release
	a_edge_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(press_event && release_event))
		else $error("press and release in the same word");

	// short press only on a release tick
	a_short_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && short_press |-> release_event)
		else $error("short press without release");

	// a press leaves the debounced level low
	a_press_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && press_event |-> !stable_level)
		else $error("press event with released level");

	// off mode keeps the LED dark
	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && blink_mode == MODE_OFF |-> led_pin)
		else $error("LED lit in off mode");

endmodule

FILE: test/blink_check_pkg.sv
`timescale 1ns / 1ps

package blink_check_pkg;

	import bdl_pkg::*;

	typedef struct packed {
		logic        led_pin;
		blink_mode_t blink_mode;
		logic        stable_level;
		logic        press_event;
		logic        release_event;
		logic        short_press;
		logic        long_press;
	} tick_word_t;

	class tick_scoreboard;

		logic [15:0] debounce_lim, short_lim, long_lim, slow_lim, fast_lim;
		logic        latched_raw, settle_armed, stable_cur, stable_old, long_armed, pin;
		logic [15:0] settle_cnt, hold_cnt, slow_cnt, fast_cnt;
		blink_mode_t mode;
		tick_word_t  expected_ticks[$];
		int          mismatches;

		function new();
			debounce_lim = DEBOUNCE_TICKS_RST;
			short_lim    = SHORT_PRESS_MAX_RST;
			long_lim     = LONG_PRESS_MIN_RST;
			slow_lim     = SLOW_HALF_PERIOD_RST;
			fast_lim     = FAST_HALF_PERIOD_RST;
			latched_raw  = 1'b1;
			settle_armed = 1'b0;
			settle_cnt   = '0;
			stable_cur   = 1'b1;
			stable_old   = 1'b1;
			long_armed   = 1'b0;
			hold_cnt     = '0;
			mode         = MODE_OFF;
			pin          = 1'b1;
			slow_cnt     = '0;
			fast_cnt     = '0;
			mismatches   = 0;
		endfunction

		static function logic [15:0] sat_bump(logic [15:0] v);
			return (v == 16'hFFFF) ? v : v + 16'd1;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [15:0] v);
			case (idx)
				REG_DEBOUNCE_TICKS:   debounce_lim = v;
				REG_SHORT_PRESS_MAX:  short_lim = v;
				REG_LONG_PRESS_MIN:   long_lim = v;
				REG_SLOW_HALF_PERIOD: slow_lim = v;
				REG_FAST_HALF_PERIOD: fast_lim = v;
				default: ;
			endcase
		endfunction

		// Advance one millisecond tick and queue the word it should produce.
		function void take_tick(logic raw);
			tick_word_t w;
			w = '0;
			settle_cnt = sat_bump(settle_cnt);
			hold_cnt   = sat_bump(hold_cnt);
			slow_cnt   = sat_bump(slow_cnt);
			fast_cnt   = sat_bump(fast_cnt);

			if (raw != latched_raw) begin
				latched_raw  = raw;
				settle_armed = 1'b1;
				settle_cnt   = '0;
			end
			if (settle_armed && settle_cnt >= debounce_lim) begin
				stable_cur   = latched_raw;
				settle_armed = 1'b0;
			end

			if (stable_cur != stable_old) begin
				if (!stable_cur) begin
					w.press_event = 1'b1;
					case (mode)
						MODE_SLOW: mode = MODE_FAST;
						MODE_FAST: mode = MODE_OFF;
						default:   mode = MODE_SLOW;
					endcase
					long_armed = 1'b1;
					hold_cnt   = '0;
				end else begin
					w.release_event = 1'b1;
					w.short_press   = (hold_cnt <= short_lim);
					long_armed      = 1'b0;
				end
				stable_old = stable_cur;
			end

			if (long_armed && hold_cnt >= long_lim) begin
				w.long_press = 1'b1;
				long_armed   = 1'b0;
			end

			case (mode)
				MODE_SLOW: if (slow_cnt >= slow_lim) begin
					pin      = ~pin;
					slow_cnt = '0;
				end
				MODE_FAST: if (fast_cnt >= fast_lim) begin
					pin      = ~pin;
					fast_cnt = '0;
				end
				default: pin = 1'b1;
			endcase

			w.led_pin      = pin;
			w.blink_mode   = mode;
			w.stable_level = stable_cur;
			expected_ticks.push_back(w);
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("%0t ns  mismatch: %s", $time, msg);
		endfunction

		function void cmp_field(string name, logic [1:0] got, logic [1:0] want);
			if (got !== want)
				report($sformatf("%s got %b want %b", name, got, want));
		endfunction

		function void check_word(tick_word_t got);
			tick_word_t want;
			if (expected_ticks.size() == 0) begin
				report("output word with no tick pending");
				return;
			end
			want = expected_ticks.pop_front();
			cmp_field("led_pin", got.led_pin, want.led_pin);
			cmp_field("blink_mode", got.blink_mode, want.blink_mode);
			cmp_field("stable_level", got.stable_level, want.stable_level);
			cmp_field("press_event", got.press_event, want.press_event);
			cmp_field("release_event", got.release_event, want.release_event);
			cmp_field("short_press", got.short_press, want.short_press);
			cmp_field("long_press", got.long_press, want.long_press);
		endfunction

		function int pending();
			return expected_ticks.size();
		endfunction

	endclass

endpackage

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

	import bdl_pkg::*;
	import blink_check_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 raw_level;
	logic                 out_valid;
	logic                 out_ready;
	logic                 led_pin;
	logic [1:0]           blink_mode;
	logic                 stable_level;
	logic                 press_event;
	logic                 release_event;
	logic                 short_press;
	logic                 long_press;

	tick_scoreboard sb = new();

	// Sender and receiver knobs, flipped per phase by the main sequence
	bit   tx_gaps    = 1'b0;
	bit   rx_stalls  = 1'b0;
	int   rx_hold    = 0;
	int   burst_left = 0;
	int   sent_count = 0;
	logic last_raw   = 1'b1;

	button_debounce_led_mode_blinker_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.raw_level     (raw_level),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.led_pin       (led_pin),
		.blink_mode    (blink_mode),
		.stable_level  (stable_level),
		.press_event   (press_event),
		.release_event (release_event),
		.short_press   (short_press),
		.long_press    (long_press)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Receiver: drive ready at the falling edge. A pending hold-off wins over
	// everything and is counted down here, once per falling edge; otherwise
	// alternate ready and stall runs of random length when stalls are on.
	initial begin : receiver
		bit run_ready;
		int run_left;
		run_ready = 1'b1;
		run_left  = 0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else if (!rx_stalls) begin
				out_ready <= 1'b1;
			end else begin
				if (run_left == 0) begin
					run_ready = !run_ready;
					run_left  = run_ready ? $urandom_range(1, 12) : $urandom_range(1, 7);
				end
				run_left--;
				out_ready <= run_ready;
			end
		end
	end

	// Check every word the block hands over, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word(tick_word_t'{led_pin, blink_mode_t'(blink_mode), stable_level,
				press_event, release_event, short_press, long_press});
	end

	// Offer one tick word and hold it until taken. Called at a falling edge and
	// returns at a falling edge. With gaps on, drop valid between bursts.
	task automatic send_tick(input logic lvl);
		if (tx_gaps && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		in_valid  <= 1'b1;
		raw_level <= lvl;
		do
			@(posedge clk);
		while (!in_ready);
		sb.take_tick(lvl);
		if (burst_left > 0)
			burst_left--;
		sent_count++;
		last_raw = lvl;
		@(negedge clk);
	endtask

	// Play a stream of button gestures: mostly a clean level change with some
	// contact chatter in front of it and a random hold, the rest raw noise.
	task automatic play_button(input int n_items, input int hold_max, input int chatter_max);
		int   stop_at;
		int   bounces;
		logic lvl;
		stop_at = sent_count + n_items;
		while (sent_count < stop_at) begin
			if ($urandom_range(0, 9) < 8) begin
				lvl     = ~last_raw;
				bounces = $urandom_range(0, 3);
				repeat (bounces) begin
					repeat ($urandom_range(1, chatter_max)) send_tick(lvl);
					repeat ($urandom_range(1, chatter_max)) send_tick(~lvl);
				end
				repeat ($urandom_range(1, hold_max)) send_tick(lvl);
			end else begin
				repeat ($urandom_range(1, 6)) begin
					lvl = 1'($urandom_range(0, 1));
					send_tick(lvl);
				end
			end
		end
	endtask

	// Drop valid and hold the stimulus until every predicted word has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic program_reg(input cfg_reg_t idx, input logic [15:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		sb.write_reg(idx, v);
		@(negedge clk);
	endtask

	// Write all five registers back to back, then drop the enable once
	task automatic set_regs(input logic [15:0] dbnc, input logic [15:0] short_max,
			input logic [15:0] long_min, input logic [15:0] slow_hp,
			input logic [15:0] fast_hp);
		program_reg(REG_DEBOUNCE_TICKS, dbnc);
		program_reg(REG_SHORT_PRESS_MAX, short_max);
		program_reg(REG_LONG_PRESS_MIN, long_min);
		program_reg(REG_SLOW_HALF_PERIOD, slow_hp);
		program_reg(REG_FAST_HALF_PERIOD, fast_hp);
		cfg_wr_en <= 1'b0;
	endtask

	// Main sequence
	initial begin : main_seq
		logic [19:0] directed;
		logic [15:0] dbnc, short_max, long_min, slow_hp, fast_hp;

		// Press, hold, release, and walk the mode through all three values,
		// read from bit 0 upward
		directed = 20'b1110_1001_0101_1001_0100;

		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		raw_level = 1'b1;
		out_ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults: presses settle after 15 ticks, the first one steps into slow blink
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		play_button(150, 60, 8);
		drain();

		// Zero thresholds: every change settles at once, long press fires on the
		// press tick and either blink mode toggles the pin every tick
		tx_gaps   = 1'b0;
		rx_stalls = 1'b0;
		set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		for (int i = 0; i < 20; i++)
			send_tick(directed[i]);
		drain();

		// Random small thresholds so that every event shows up often. The first
		// phase runs with no idling at all; two phases hold the receiver off long
		// enough to back the block up into its input.
		for (int p = 0; p < 6; p++) begin
			dbnc      = 16'($urandom_range(0, 8));
			short_max = 16'($urandom_range(0, 40));
			long_min  = 16'($urandom_range(0, 80));
			slow_hp   = 16'($urandom_range(0, 12));
			fast_hp   = 16'($urandom_range(0, 6));
			set_regs(dbnc, short_max, long_min, slow_hp, fast_hp);
			tx_gaps   = (p != 0);
			rx_stalls = (p != 0);
			if (p == 2 || p == 4)
				rx_hold = 300;
			play_button(120, long_min + dbnc + 30, dbnc + 2);
			// Pause the sender until the block is empty, then carry on
			drain();
			play_button(130, long_min + dbnc + 30, dbnc + 2);
			drain();
		end

		// Top of every register: nothing ever settles or toggles
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		play_button(100, 40, 4);
		drain();

		// Mixed extremes: every release counts as short, fast blink flips often
		set_regs(16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
		play_button(150, 20, 3);
		drain();

		// Let the pipeline settle and catch any stray word
		repeat (6) @(posedge clk);
		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog, well past the slowest legal run
	initial begin : watchdog
		#(5_000_000);
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
hdl/bdl_pkg.sv
hdl/bdl_debounce.sv
hdl/bdl_press.sv
hdl/bdl_blink.sv
hdl/button_debounce_led_mode_blinker_unit.sv
test/blink_check_pkg.sv
test/tb.sv
